@@ design/bounded_multi_queue_dispatch_macros.svh @@
// ----------------------------------------------------------------------------
// bounded_multi_queue_dispatch_macros
// Assertion macros for the dispatcher checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_MULTI_QUEUE_DISPATCH_MACROS_SVH
`define BOUNDED_MULTI_QUEUE_DISPATCH_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define BMQD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmqd check failed");

// Next-cycle implication, ignored while in reset.
`define BMQD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmqd check failed");

// Next-cycle implication that also holds across reset.
`define BMQD_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bmqd check failed");

`endif

@@ design/bmqd_pkg.sv @@
// ----------------------------------------------------------------------------
// bmqd_pkg
// Shared types and constants of the bounded multi-queue dispatcher.
// ----------------------------------------------------------------------------
package bmqd_pkg;

  localparam int MAX_SERVERS = 32;
  localparam int MAX_QUEUE   = 16;
  localparam int SRV_W       = $clog2(MAX_SERVERS);
  localparam int SLOT_W      = $clog2(MAX_QUEUE);
  localparam int NCNT_W      = $clog2(MAX_SERVERS + 1);
  localparam int MCNT_W      = $clog2(MAX_QUEUE + 1);

  localparam logic [10:0] OPEN_DEFAULT  = 11'(8 * 60);
  localparam logic [10:0] CLOSE_DEFAULT = 11'(17 * 60);

  // finish / 60 as (finish * DIV_K) >> DIV_SHIFT, exact for 16-bit finish
  localparam int          DIV_SHIFT = 22;
  localparam logic [16:0] DIV_K     = 17'(((1 << DIV_SHIFT) + 59) / 60);
  localparam logic [15:0] MIN_PER_HOUR = 16'd60;

  localparam logic [1:0] REG_WINDOW_COUNT = 2'd0;
  localparam logic [1:0] REG_QUEUE_DEPTH  = 2'd1;
  localparam logic [1:0] REG_OPEN_TIME    = 2'd2;
  localparam logic [1:0] REG_CLOSE_TIME   = 2'd3;

  typedef struct packed {
    logic [7:0]        service_time;
    logic              fill;
    logic              first;
    logic [SRV_W-1:0]  srv;
    logic [SLOT_W-1:0] slot;
  } job_t;

  typedef struct packed {
    logic [NCNT_W-1:0] n_eff;
    logic [MCNT_W-1:0] m_eff;
    logic [10:0]       open_time;
    logic [10:0]       close_time;
    logic              restart;
  } cfg_t;

endpackage

@@ design/bmqd_if.sv @@
// ----------------------------------------------------------------------------
// bmqd_in_if / bmqd_out_if
// Valid/ready channels of the dispatcher: job words in, result words out.
// ----------------------------------------------------------------------------
interface bmqd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] service_time;

  modport source (output valid, output service_time, input ready);
  modport sink   (input valid, input service_time, output ready);
endinterface

interface bmqd_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  server_index;
  logic [15:0] finish_time;
  logic [10:0] finish_hour;
  logic [5:0]  finish_minute;
  logic        served;

  modport source (output valid, output server_index, output finish_time,
                  output finish_hour, output finish_minute, output served,
                  input ready);
  modport sink   (input valid, input server_index, input finish_time,
                  input finish_hour, input finish_minute, input served,
                  output ready);
endinterface

@@ design/bmqd_front.sv @@
// ----------------------------------------------------------------------------
// bmqd_front
// Accepts job words and tags each with its fill-phase server and slot.
// ----------------------------------------------------------------------------
module bmqd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bmqd_pkg::cfg_t        cfg,
  bmqd_in_if.sink               in_ch,
  input  logic                  q_full,
  output logic                  q_push,
  output bmqd_pkg::job_t        q_job
);
  import bmqd_pkg::*;

  logic [SRV_W-1:0]  srv_cnt_r, srv_cnt_nxt;
  logic [MCNT_W-1:0] row_r, row_nxt;
  logic              fill;
  logic              last_srv;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign fill        = row_r < cfg.m_eff;
  assign last_srv    = NCNT_W'(srv_cnt_r) == cfg.n_eff - NCNT_W'(1);

  always_comb begin
    q_job.service_time = in_ch.service_time;
    q_job.fill         = fill;
    q_job.first        = row_r == '0;
    q_job.srv          = srv_cnt_r;
    q_job.slot         = row_r[SLOT_W-1:0];
  end

  always_comb begin
    srv_cnt_nxt = srv_cnt_r;
    row_nxt     = row_r;
    if (q_push && fill) begin
      if (last_srv) begin
        srv_cnt_nxt = '0;
        row_nxt     = row_r + MCNT_W'(1);
      end else begin
        srv_cnt_nxt = srv_cnt_r + SRV_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.restart) begin
      srv_cnt_r <= '0;
      row_r     <= '0;
    end else begin
      srv_cnt_r <= srv_cnt_nxt;
      row_r     <= row_nxt;
    end
  end

endmodule

@@ design/bmqd_fifo.sv @@
// ----------------------------------------------------------------------------
// bmqd_fifo
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module bmqd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bmqd_pkg::job_t push_job,
  input  logic           pop,
  output bmqd_pkg::job_t pop_job,
  output logic           full,
  output logic           empty
);
  import bmqd_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign pop_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ design/bmqd_back.sv @@
// ----------------------------------------------------------------------------
// bmqd_back
// Dispatch engine: earliest-head scan, ring memory, finish time, hour split.
// ----------------------------------------------------------------------------
module bmqd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  bmqd_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  bmqd_pkg::job_t q_job,
  output logic           q_pop,
  bmqd_out_if.source     out_ch
);
  import bmqd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam int ADDR_W = SRV_W + SLOT_W;

  logic [2:0]        state_r, state_nxt;
  job_t              job_r;
  logic [NCNT_W-1:0] scan_r;
  logic [SRV_W-1:0]  srv_r;
  logic [15:0]       best_val_r;
  logic [SLOT_W-1:0] old_r, nxt_r;
  logic [15:0]       fin_r;
  logic              served_r;
  logic [32:0]       prod_r;

  logic [15:0]       head_r [MAX_SERVERS];
  logic [15:0]       end_r  [MAX_SERVERS];
  logic [SLOT_W-1:0] ring_r [MAX_SERVERS];

  logic [15:0]       qmem [MAX_SERVERS * MAX_QUEUE];
  logic [15:0]       rdata_r;

  logic [16:0]       sum;
  logic [15:0]       fin;
  logic [15:0]       start;
  logic [SLOT_W-1:0] ring_old, ring_nxt;
  logic [10:0]       hour;
  logic [15:0]       hour_min;
  logic              out_free;
  logic              go;

  assign start    = end_r[srv_r];
  assign sum      = {1'b0, start} + 17'(job_r.service_time);
  assign fin      = sum[16] ? 16'hFFFF : sum[15:0];
  assign ring_old = ring_r[srv_r];
  assign ring_nxt = (MCNT_W'(ring_old) + MCNT_W'(1) == cfg.m_eff) ? '0
                    : ring_old + SLOT_W'(1);
  assign hour     = prod_r[DIV_SHIFT +: 11];
  assign hour_min = 16'(hour) * MIN_PER_HOUR;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign go       = state_r == S_IDLE && !q_empty && !cfg.restart;
  assign q_pop    = go;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (go) state_nxt = q_job.fill ? S_FIN : S_SCAN;
      S_SCAN: if (scan_r >= cfg.n_eff) state_nxt = S_READ;
      S_READ: state_nxt = S_FIN;
      S_FIN:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.restart) state_r <= S_IDLE;
    else                       state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      job_r      <= q_job;
      srv_r      <= q_job.srv;
      scan_r     <= NCNT_W'(1);
      best_val_r <= head_r[0];
      if (!q_job.fill) srv_r <= '0;
    end
    if (state_r == S_SCAN && scan_r < cfg.n_eff) begin
      if (head_r[scan_r[SRV_W-1:0]] < best_val_r) begin
        best_val_r <= head_r[scan_r[SRV_W-1:0]];
        srv_r      <= scan_r[SRV_W-1:0];
      end
      scan_r <= scan_r + NCNT_W'(1);
    end
    if (state_r == S_READ) begin
      old_r <= ring_old;
      nxt_r <= ring_nxt;
    end
    if (state_r == S_FIN) begin
      fin_r    <= fin;
      served_r <= start < 16'(cfg.close_time);
    end
    if (state_r == S_MUL) prod_r <= 33'(fin_r) * 33'(DIV_K);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) rdata_r <= qmem[{srv_r, ring_nxt}];
    if (state_r == S_FIN) begin
      if (job_r.fill) qmem[ADDR_W'({srv_r, job_r.slot})] <= fin;
      else            qmem[ADDR_W'({srv_r, old_r})]      <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.restart) begin
      for (int s = 0; s < MAX_SERVERS; s++) begin
        head_r[s] <= !rst_n ? 16'(OPEN_DEFAULT) : 16'(cfg.open_time);
        end_r[s]  <= !rst_n ? 16'(OPEN_DEFAULT) : 16'(cfg.open_time);
        ring_r[s] <= '0;
      end
    end else if (state_r == S_FIN) begin
      end_r[srv_r] <= fin;
      if (job_r.fill) begin
        if (job_r.first) head_r[srv_r] <= fin;
      end else begin
        head_r[srv_r] <= (cfg.m_eff == MCNT_W'(1)) ? fin : rdata_r;
        ring_r[srv_r] <= nxt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ch.valid <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_ch.server_index  <= srv_r;
      out_ch.finish_time   <= fin_r;
      out_ch.finish_hour   <= hour;
      out_ch.finish_minute <= 6'(fin_r - hour_min);
      out_ch.served        <= served_r;
    end
  end

endmodule

@@ design/bounded_multi_queue_dispatch.sv @@
// ----------------------------------------------------------------------------
// bounded_multi_queue_dispatch
// Dispatches jobs to bounded server queues and reports finish times.
//
//   channel | dir | payload
//   in_ch   | in  | service_time
//   out_ch  | out | server_index, finish_time, finish_hour, finish_minute,
//           |     | served
//   cfg_*   | in  | cfg_index, cfg_wdata (write only)
//
// Fill phase: a word passes the idle, finish, multiply and output states.
// Queues full: a one-server-a-cycle earliest-head scan, read, then finish.
// A config write restarts dispatch in the cycle after it; no clearing pass.
// A two-word queue lets intake run on while the engine or the output stalls.
// ----------------------------------------------------------------------------
module bounded_multi_queue_dispatch (
  input  logic        clk,
  input  logic        rst_n,
  bmqd_in_if.sink     in_ch,
  bmqd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);
  import bmqd_pkg::*;

  logic [5:0]  window_count_r;
  logic [4:0]  queue_depth_r;
  logic [10:0] open_time_r;
  logic [10:0] close_time_r;
  logic        restart_r;
  cfg_t        cfg;

  logic        q_push, q_pop, q_full, q_empty;
  job_t        push_job, pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_count_r <= 6'd1;
      queue_depth_r  <= 5'd1;
      open_time_r    <= OPEN_DEFAULT;
      close_time_r   <= CLOSE_DEFAULT;
      restart_r      <= 1'b0;
    end else begin
      restart_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_COUNT: window_count_r <= cfg_wdata[5:0];
          REG_QUEUE_DEPTH:  queue_depth_r  <= cfg_wdata[4:0];
          REG_OPEN_TIME:    open_time_r    <= cfg_wdata;
          REG_CLOSE_TIME:   close_time_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (window_count_r == '0)                        cfg.n_eff = NCNT_W'(1);
    else if (7'(window_count_r) > 7'(MAX_SERVERS))   cfg.n_eff = NCNT_W'(MAX_SERVERS);
    else                                             cfg.n_eff = NCNT_W'(window_count_r);
    if (queue_depth_r == '0)                         cfg.m_eff = MCNT_W'(1);
    else if (7'(queue_depth_r) > 7'(MAX_QUEUE))      cfg.m_eff = MCNT_W'(MAX_QUEUE);
    else                                             cfg.m_eff = MCNT_W'(queue_depth_r);
    cfg.open_time  = open_time_r;
    cfg.close_time = close_time_r;
    cfg.restart    = restart_r;
  end

  bmqd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  bmqd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  bmqd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

@@ design/bmqd_check.sv @@
// ----------------------------------------------------------------------------
// bmqd_check
// Port-level checks on the dispatcher result channel.
// ----------------------------------------------------------------------------
`include "bounded_multi_queue_dispatch_macros.svh"

module bmqd_check (
  input logic        clk,
  input logic        rst_n,
  bmqd_out_if.source out_ch
);

  `BMQD_ASSERT_ALWAYS(a_no_word_after_reset, !rst_n, !out_ch.valid)
  `BMQD_ASSERT_NOW(a_hour_split, out_ch.valid,
    (out_ch.finish_minute < 6'd60) &&
    (17'(out_ch.finish_hour) * 17'd60 + 17'(out_ch.finish_minute) ==
     17'(out_ch.finish_time)))
  `BMQD_ASSERT_NEXT(a_stall_holds, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.finish_time) && $stable(out_ch.server_index))

endmodule

bind bounded_multi_queue_dispatch bmqd_check u_check (
  .clk    (clk),
  .rst_n  (rst_n),
  .out_ch (out_ch)
);
